// ===== src/nfcrfp_pkg.sv =====
// shared types and constants of the nfc response frame parser
package nfcrfp_pkg;

   // frame parser phases
   localparam logic [3:0] PhIdle    = 4'd0;
   localparam logic [3:0] PhStart1  = 4'd1;
   localparam logic [3:0] PhStart2  = 4'd2;
   localparam logic [3:0] PhLen     = 4'd3;
   localparam logic [3:0] PhLcs     = 4'd4;
   localparam logic [3:0] PhExtHi   = 4'd5;
   localparam logic [3:0] PhExtLo   = 4'd6;
   localparam logic [3:0] PhExtCs   = 4'd7;
   localparam logic [3:0] PhTfi     = 4'd8;
   localparam logic [3:0] PhCode    = 4'd9;
   localparam logic [3:0] PhData    = 4'd10;
   localparam logic [3:0] PhDcs     = 4'd11;
   localparam logic [3:0] PhPostOk  = 4'd12;
   localparam logic [3:0] PhPostBad = 4'd13;

   // frame status codes
   typedef logic [1:0] status_type;
   localparam status_type StOk       = 2'd0;
   localparam status_type StInvalid  = 2'd1;
   localparam status_type StErrFrame = 2'd2;
   localparam status_type StNoSpace  = 2'd3;

   // configuration register indexes
   localparam int unsigned CsrIndexBits = 8;
   localparam int unsigned CsrDataBits  = 16;
   localparam logic [CsrIndexBits-1:0] CsrExpectedResponse = 8'd0;
   localparam logic [CsrIndexBits-1:0] CsrCapacity         = 8'd1;

   // frame byte values
   localparam logic [7:0] ByteZero     = 8'h00;
   localparam logic [7:0] ByteFf       = 8'hFF;
   localparam logic [7:0] ByteTfi      = 8'hD5;
   localparam logic [7:0] ByteErrTfi   = 8'h7F;
   localparam logic [7:0] ByteErrCode  = 8'h81;

   localparam logic [15:0] CapacityReset = 16'hFFFF;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        frame_done;
      status_type  status;
      logic [15:0] payload_length;
   } result_type;

   // length minus the tfi and code bytes, when there are at least two
   function automatic logic [15:0] strip_len(input logic [15:0] n);
      strip_len = (n >= 16'd2) ? n - 16'd2 : n;
   endfunction

endpackage

// ===== src/nfcrfp_if.sv =====
// handshake channels of the nfc response frame parser

interface nfcrfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface nfcrfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        frame_done;
   logic [1:0]  status;
   logic [15:0] payload_length;

   modport source (output valid, output payload_valid, output payload_byte,
                   output frame_done, output status, output payload_length, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input frame_done, input status, input payload_length, output ready);
endinterface

interface nfcrfp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/nfc_response_frame_parser.sv =====
// nfc response frame parser top level
//
// Byte-serial parser for one controller response frame: preamble, start code
// 00 00 FF, normal or extended length with its checksum, TFI D5 and the
// expected response code, payload bytes passed out as they arrive, data
// checksum and postamble. Every accepted byte gives exactly one result
// transaction in the following cycle; the whole decision for a byte is made at the
// input handshake against the phase register, so one byte is taken per cycle
// as long as the result channel keeps up. A single output register sits
// between the channels, and req ready is low only while that register holds
// a result that is not yet taken. frame_done marks the end or rejection of a
// frame with its status (0 ok, 1 invalid, 2 error frame, 3 no space);
// payload_length is given with a good frame. A byte with frame_start set
// always begins a new frame. Configuration writes are taken in any cycle.
module nfc_response_frame_parser #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   nfcrfp_req_if.sink   req_chan,
   nfcrfp_rsp_if.source rsp_chan,
   nfcrfp_csr_if.sink   csr_chan
);
   import nfcrfp_pkg::*;

   localparam logic [16:0] LenLimit = 17'((32'd1 << LENGTH_BITS) - 32'd1);

   logic [7:0]             expected_ff;
   logic [15:0]            capacity_ff;

   logic [3:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] byte_count_ff, byte_count_in;
   logic [7:0]             run_sum_ff, run_sum_in;
   logic [15:0]            pay_len_ff, pay_len_in;
   logic [7:0]             len_high_ff, len_high_in;
   logic [7:0]             len_low_ff, len_low_in;

   logic                   rsp_valid_ff;
   result_type             rsp_ff, result;

   logic                   req_take;
   logic [7:0]             b;
   logic [7:0]             lcs_sum;
   logic [7:0]             ext_sum;
   logic [7:0]             dcs_sum;
   logic [15:0]            ext_len;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   assign csr_chan.ready = 1'b1;

   assign lcs_sum = len_low_ff + b;
   assign ext_sum = len_high_ff + len_low_ff + b;
   assign dcs_sum = run_sum_ff + b;
   assign ext_len = strip_len({len_high_ff, len_low_ff});

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      run_sum_in    = run_sum_ff;
      pay_len_in    = pay_len_ff;
      len_high_in   = len_high_ff;
      len_low_in    = len_low_ff;
      result        = '0;

      if (req_chan.frame_start) begin
         byte_count_in = '0;
         run_sum_in    = '0;
         pay_len_in    = '0;
         len_high_in   = '0;
         len_low_in    = '0;
         if (b == ByteZero) begin
            phase_in = PhStart1;
         end else begin
            result.frame_done = 1'b1;
            result.status     = StInvalid;
            phase_in          = PhIdle;
         end
      end else begin
         case (phase_ff)
            PhStart1: begin
               if (b == ByteZero) begin
                  phase_in = PhStart2;
               end else begin
                  result.frame_done = 1'b1;
                  result.status     = StInvalid;
                  phase_in          = PhIdle;
               end
            end
            PhStart2: begin
               if (b == ByteFf) begin
                  phase_in = PhLen;
               end else begin
                  result.frame_done = 1'b1;
                  result.status     = StInvalid;
                  phase_in          = PhIdle;
               end
            end
            PhLen: begin
               len_low_in = b;
               phase_in   = PhLcs;
            end
            PhLcs: begin
               if (len_low_ff == ByteFf && b == ByteFf) begin
                  phase_in = PhExtHi;
               end else if (lcs_sum != ByteZero) begin
                  result.frame_done = 1'b1;
                  result.status     = StInvalid;
                  phase_in          = PhIdle;
               end else begin
                  pay_len_in = strip_len({8'd0, len_low_ff});
                  phase_in   = PhTfi;
               end
            end
            PhExtHi: begin
               len_high_in = b;
               phase_in    = PhExtLo;
            end
            PhExtLo: begin
               len_low_in = b;
               phase_in   = PhExtCs;
            end
            PhExtCs: begin
               if (ext_sum != ByteZero) begin
                  result.frame_done = 1'b1;
                  result.status     = StInvalid;
                  phase_in          = PhIdle;
               end else begin
                  pay_len_in = ext_len;
                  phase_in   = PhTfi;
               end
            end
            PhTfi: begin
               run_sum_in = b;
               phase_in   = PhCode;
            end
            PhCode: begin
               if (pay_len_ff == 16'd1 && run_sum_ff == ByteErrTfi && b == ByteErrCode) begin
                  result.frame_done = 1'b1;
                  result.status     = StErrFrame;
                  phase_in          = PhIdle;
               end else if (run_sum_ff != ByteTfi || b != expected_ff) begin
                  result.frame_done = 1'b1;
                  result.status     = StInvalid;
                  phase_in          = PhIdle;
               end else if (pay_len_ff > capacity_ff || {1'b0, pay_len_ff} > LenLimit) begin
                  result.frame_done = 1'b1;
                  result.status     = StNoSpace;
                  phase_in          = PhIdle;
               end else begin
                  run_sum_in    = dcs_sum;
                  byte_count_in = '0;
                  phase_in      = (pay_len_ff != 16'd0) ? PhData : PhDcs;
               end
            end
            PhData: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = b;
               run_sum_in           = dcs_sum;
               byte_count_in        = byte_count_ff + 1'b1;
               if (16'(byte_count_in) >= pay_len_ff) begin
                  phase_in = PhDcs;
               end
            end
            PhDcs: begin
               phase_in = (dcs_sum == ByteZero) ? PhPostOk : PhPostBad;
            end
            PhPostOk: begin
               result.frame_done     = 1'b1;
               result.status         = StOk;
               result.payload_length = pay_len_ff;
               phase_in              = PhIdle;
            end
            PhPostBad: begin
               result.frame_done = 1'b1;
               result.status     = StInvalid;
               phase_in          = PhIdle;
            end
            default: begin
               phase_in = PhIdle;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhIdle;
         byte_count_ff <= '0;
         run_sum_ff    <= '0;
         pay_len_ff    <= '0;
         len_high_ff   <= '0;
         len_low_ff    <= '0;
      end else if (req_take) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         run_sum_ff    <= run_sum_in;
         pay_len_ff    <= pay_len_in;
         len_high_ff   <= len_high_in;
         len_low_ff    <= len_low_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         capacity_ff <= CapacityReset;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CsrExpectedResponse: expected_ff <= csr_chan.data[7:0];
            CsrCapacity:         capacity_ff <= csr_chan.data;
            default:             ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.payload_valid  = rsp_ff.payload_valid;
   assign rsp_chan.payload_byte   = rsp_ff.payload_byte;
   assign rsp_chan.frame_done     = rsp_ff.frame_done;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.payload_length = rsp_ff.payload_length;

   // a payload byte never closes a frame
   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.payload_valid |-> !rsp_ff.frame_done)
      else $error("payload byte reported together with frame end");

   // status and length stay zero unless the frame ends
   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_done |->
         rsp_ff.status == StOk && rsp_ff.payload_length == 16'd0)
      else $error("status or length reported without frame end");

   // a frame end always returns the parser to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      req_take && result.frame_done |=> phase_ff == PhIdle)
      else $error("parser not idle after frame end");

   // the payload counter never passes the frame length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhData |-> 16'(byte_count_ff) < pay_len_ff)
      else $error("payload count beyond frame length");

   // a stalled result transaction holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");

endmodule
